// ----- src/tcas_pkg.sv -----
package tcas_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int CFG_W    = 8;
  localparam int LVL_W    = 17;
  localparam int SUM_W    = LVL_W + 2;

  localparam logic [LVL_W-1:0] LEVEL_ONE  = LVL_W'(65536);
  localparam logic [LVL_W-1:0] LEVEL_HALF = LVL_W'(32768);
  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(100);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    RD_HOST,
    RD_CL,
    RD_RU,
    RD_D
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_HOST,
    WR_CELL,
    WR_COPY
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ZERO,
    RES_READ,
    RES_STEP
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    rd_sel_t  rd_sel;
    logic     cap_first;
    logic     cap_second;
    logic     cap_down;
    logic     cap_diff;
    wr_sel_t  wr_sel;
    logic     advance;
    logic     flip;
    res_sel_t res_sel;
  } tcas_cmd_t;

  typedef struct packed {
    logic active;
    logic last;
  } tcas_stat_t;

endpackage

// ----- src/tcas_ctrl.sv -----
module tcas_ctrl
  import tcas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_req_type,
  input  tcas_stat_t stat,
  output tcas_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_RDATA,
    S_RD0,
    S_RD1,
    S_RD2,
    S_AVG,
    S_DIF,
    S_WR,
    S_CPY,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = RD_HOST;
    cmd.wr_sel    = WR_NONE;
    cmd.res_sel   = RES_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          unique case (in_req_type)
            REQ_WRITE: state_nxt = S_WRITE;
            REQ_READ:  state_nxt = S_READ;
            REQ_STEP:  state_nxt = S_RD0;
            default: begin
              // An unknown request answers at once with an all-zero result.
              cmd.res_sel   = RES_ZERO;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr_sel    = WR_HOST;
        cmd.res_sel   = RES_ZERO;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        cmd.rd_sel = RD_HOST;
        state_nxt  = S_RDATA;
      end
      S_RDATA: begin
        cmd.res_sel   = RES_READ;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_RD0: begin
        cmd.rd_sel = RD_CL;
        state_nxt  = stat.active ? S_RD1 : S_CPY;
      end
      S_RD1: begin
        cmd.rd_sel    = RD_RU;
        cmd.cap_first = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel     = RD_D;
        cmd.cap_second = 1'b1;
        state_nxt      = S_AVG;
      end
      S_AVG: begin
        cmd.cap_down = 1'b1;
        state_nxt    = S_DIF;
      end
      S_DIF: begin
        cmd.cap_diff = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR, S_CPY: begin
        cmd.wr_sel = (state_r == S_WR) ? WR_CELL : WR_COPY;
        if (stat.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_RD0;
        end
      end
      S_DONE: begin
        cmd.flip      = 1'b1;
        cmd.res_sel   = RES_STEP;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/tcas_dp.sv -----
module tcas_dp
  import tcas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tcas_cmd_t        cmd,
  output tcas_stat_t       stat,
  input  logic [COL_W-1:0] in_cell_col,
  input  logic [ROW_W-1:0] in_cell_row,
  input  logic [LVL_W-1:0] in_cell_value,
  input  logic [CFG_W-1:0] grid_cols,
  input  logic [CFG_W-1:0] grid_rows,
  output logic [LVL_W-1:0] out_read_level,
  output logic             out_step_done
);

  logic [LVL_W-1:0] bank_a [CELLS];
  logic [LVL_W-1:0] bank_b [CELLS];

  logic [COL_W-1:0]  col_r, c_r;
  logic [ROW_W-1:0]  row_r, r_r;
  logic [LVL_W-1:0]  val_r;
  logic              cur_bank_r;
  logic [LVL_W-1:0]  cur_lvl_r, diff_r;
  logic [SUM_W-1:0]  sum_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_done_r;

  logic [LVL_W-1:0]  rda0_r, rda1_r, rdb0_r, rdb1_r;
  logic [LVL_W-1:0]  rd0, rd1;
  logic [ADDR_W-1:0] ra0, ra1, wa;
  logic [LVL_W-1:0]  wd, avg;
  logic              we, wbank;
  logic [CFG_W-1:0]  cols_eff, rows_eff;
  logic [COL_W-1:0]  cl, cr;
  logic [ROW_W-1:0]  ru, rd;
  logic [LVL_W:0]    t;

  // Active size is the register clamped into [1, max].
  always_comb begin
    if (grid_cols == '0) begin
      cols_eff = CFG_W'(1);
    end else if (grid_cols > CFG_W'(MAX_COLS)) begin
      cols_eff = CFG_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols;
    end
    if (grid_rows == '0) begin
      rows_eff = CFG_W'(1);
    end else if (grid_rows > CFG_W'(MAX_ROWS)) begin
      rows_eff = CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
  end

  always_comb begin
    logic [CFG_W-1:0] cm1, rm1;
    cm1 = cols_eff - CFG_W'(1);
    rm1 = rows_eff - CFG_W'(1);
    cl  = (c_r == '0) ? cm1[COL_W-1:0] : c_r - COL_W'(1);
    cr  = (CFG_W'(c_r) == cm1) ? '0 : c_r + COL_W'(1);
    ru  = (r_r == '0) ? rm1[ROW_W-1:0] : r_r - ROW_W'(1);
    rd  = (CFG_W'(r_r) == rm1) ? '0 : r_r + ROW_W'(1);
  end

  assign stat.active = (CFG_W'(c_r) < cols_eff) && (CFG_W'(r_r) < rows_eff);
  assign stat.last   = (c_r == COL_W'(MAX_COLS - 1)) && (r_r == ROW_W'(MAX_ROWS - 1));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HOST: begin
        ra0 = {col_r, row_r};
        ra1 = {col_r, row_r};
      end
      RD_CL: begin
        ra0 = {c_r, r_r};
        ra1 = {cl, r_r};
      end
      RD_RU: begin
        ra0 = {cr, r_r};
        ra1 = {c_r, ru};
      end
      RD_D: begin
        ra0 = {c_r, rd};
        ra1 = {c_r, rd};
      end
      default: begin
        ra0 = {col_r, row_r};
        ra1 = {col_r, row_r};
      end
    endcase
  end

  // Reads always come from the current bank; the step writes the other one.
  assign rd0 = cur_bank_r ? rdb0_r : rda0_r;
  assign rd1 = cur_bank_r ? rdb1_r : rda1_r;

  assign avg = sum_r[SUM_W-1:2];
  assign t   = {cur_lvl_r, 1'b0} + {1'b0, diff_r};

  always_comb begin
    we    = 1'b1;
    wbank = ~cur_bank_r;
    wa    = {c_r, r_r};
    wd    = rd0;
    unique case (cmd.wr_sel)
      WR_NONE: we = 1'b0;
      WR_HOST: begin
        wbank = cur_bank_r;
        wa    = {col_r, row_r};
        wd    = (val_r > LEVEL_ONE) ? LEVEL_ONE : val_r;
      end
      WR_CELL: begin
        // New level is 2*cur + |avg - cur| - half, clamped to [0, one].
        if (t < {1'b0, LEVEL_HALF}) begin
          wd = '0;
        end else if (t > ({1'b0, LEVEL_HALF} + {1'b0, LEVEL_ONE})) begin
          wd = LEVEL_ONE;
        end else begin
          wd = LVL_W'(t - {1'b0, LEVEL_HALF});
        end
      end
      WR_COPY: wd = rd0;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      bank_a[wa] <= wd;
    end
    rda0_r <= bank_a[ra0];
    rda1_r <= bank_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (we && wbank) begin
      bank_b[wa] <= wd;
    end
    rdb0_r <= bank_b[ra0];
    rdb1_r <= bank_b[ra1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      col_r <= in_cell_col;
      row_r <= in_cell_row;
      val_r <= in_cell_value;
    end
    if (cmd.cap_first) begin
      cur_lvl_r <= rd0;
      sum_r     <= SUM_W'(rd1);
    end
    if (cmd.cap_second) begin
      sum_r <= sum_r + SUM_W'(rd0) + SUM_W'(rd1);
    end
    if (cmd.cap_down) begin
      sum_r <= sum_r + SUM_W'(rd0);
    end
    if (cmd.cap_diff) begin
      diff_r <= (avg >= cur_lvl_r) ? (avg - cur_lvl_r) : (cur_lvl_r - avg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_bank_r  <= 1'b0;
      c_r         <= '0;
      r_r         <= '0;
      out_level_r <= '0;
      out_done_r  <= 1'b0;
    end else begin
      if (cmd.flip) begin
        cur_bank_r <= ~cur_bank_r;
      end
      if (cmd.load_req) begin
        c_r <= '0;
        r_r <= '0;
      end else if (cmd.advance) begin
        if (r_r == ROW_W'(MAX_ROWS - 1)) begin
          r_r <= '0;
          c_r <= c_r + COL_W'(1);
        end else begin
          r_r <= r_r + ROW_W'(1);
        end
      end
      unique case (cmd.res_sel)
        RES_NONE: ;
        RES_ZERO: begin
          out_level_r <= '0;
          out_done_r  <= 1'b0;
        end
        RES_READ: begin
          out_level_r <= rd0;
          out_done_r  <= 1'b0;
        end
        RES_STEP: begin
          out_level_r <= '0;
          out_done_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_read_level = out_level_r;
  assign out_step_done  = out_done_r;

endmodule

// ----- src/toroidal_continuous_automaton_step.sv -----
// Grid of 128 x 128 cell levels (17-bit fixed point, 65536 is 1.0) held in two banks,
// with write, read and step requests taken on start while busy is low. Every request
// gives one result, shown on the out_ ports for a single cycle under out_valid; the
// receiver cannot stall it. A write passes through the write state and a read through
// the read and read-data states before the result. A step sweeps all 16384 cells of
// the memory in order: a cell inside the active grid goes through RD0, RD1, RD2, AVG,
// DIF and WR (its five levels are read by two ports in RD0, RD1 and RD2 and summed,
// the difference is taken in DIF and the clamp applied in WR); a cell outside is copied
// through RD0 and CPY, and the step ends in DONE. The banks are not cleared at reset;
// read or step only over cells that have been written. The grid size registers may be
// written only while the block is idle.
module toroidal_continuous_automaton_step
  import tcas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [COL_W-1:0] in_cell_col,
  input  logic [ROW_W-1:0] in_cell_row,
  input  logic [LVL_W-1:0] in_cell_value,
  output logic             out_valid,
  output logic [LVL_W-1:0] out_read_level,
  output logic             out_step_done,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_IDX_ROWS = 1'b1;

  logic [CFG_W-1:0] grid_cols_r, grid_rows_r;
  logic             cfg_wr;
  tcas_cmd_t        cmd;
  tcas_stat_t       stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_IDX_ROWS) ? 32'(grid_rows_r) : 32'(grid_cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_RESET;
      grid_rows_r <= GRID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IDX_ROWS) begin
        grid_rows_r <= pwdata[CFG_W-1:0];
      end else begin
        grid_cols_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  tcas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  tcas_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .in_cell_value  (in_cell_value),
    .grid_cols      (grid_cols_r),
    .grid_rows      (grid_rows_r),
    .out_read_level (out_read_level),
    .out_step_done  (out_step_done)
  );

endmodule

// ----- src/tcas_chk.sv -----
module tcas_chk
  import tcas_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [LVL_W-1:0] out_read_level,
  input logic             out_step_done
);

  // Every accepted transfer either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // The block only leaves busy by delivering a result.
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_step_done || (out_read_level == '0)))
    else $error("step result carries a read level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_level <= LEVEL_ONE))
    else $error("read level above one");

endmodule

bind toroidal_continuous_automaton_step tcas_chk u_tcas_chk (.*);
